// ===== design/sha0_pkg.sv =====
// sha0_pkg: shared types, constants and round helpers of the sha-0 hasher
// no dependencies; used by sha0_round and sha0_message_hash
`default_nettype none

package sha0_pkg;

    localparam int RoundCount = 80;
    localparam int WordCount  = 5;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    localparam logic [7:0] PadMark = 8'h80;

    localparam logic       KindByte   = 1'b0;
    localparam logic       KindFinish = 1'b1;

    localparam logic [6:0] LastRound = 7'(RoundCount - 1);
    localparam logic [2:0] LastWord  = 3'(WordCount - 1);

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } t_round_state;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PAD   = 6'b000010,
        ST_ROUND = 6'b000100,
        ST_FOLD  = 6'b001000,
        ST_OUT   = 6'b010000,
        ST_ERR   = 6'b100000
    } t_state;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

endpackage

`default_nettype wire

// ===== design/sha0_message_hash.sv =====
// sha0_message_hash: streaming sha-0 hasher, byte input, five-word digest output
// depends on sha0_pkg and sha0_round
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_kind, i_data_byte
//  out      output     o_out_valid / i_out_ready o_digest_word, o_word_index,
//                                                o_last_word, o_length_error
//
// each message byte is accepted directly; the 64th byte of a block starts 80 rounds
// on the single shared round unit, then a fold into the chain value
// a finish inserts padding (up to 72 bytes) one byte a cycle outside the one
// or two compressions, then presents five digest beats, one per accepted beat
// the input is not ready while padding, compressing or presenting the digest
// reset is synchronous active low and restores the initial chain value
`default_nettype none

module sha0_message_hash (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_digest_word,
    output logic [2:0]       o_word_index,
    output logic             o_last_word,
    output logic             o_length_error
);

    sha0_pkg::t_state       r_state, n_state;
    logic [31:0]            r_chain [5];
    logic [31:0]            n_chain [5];
    logic [31:0]            r_w [16];
    logic [31:0]            n_w [16];
    sha0_pkg::t_round_state r_rs, n_rs, round_out;
    logic [6:0]             r_round, n_round;
    logic [63:0]            r_bit_count, n_bit_count;
    logic [5:0]             r_pos, n_pos;
    logic                   r_overflow, n_overflow;
    logic                   r_mark_sent, n_mark_sent;
    logic                   r_fill, n_fill;
    logic                   r_last_block, n_last_block;
    logic                   r_padding, n_padding;
    logic [2:0]             r_idx, n_idx;

    logic                   in_beat;
    logic                   out_beat;
    logic                   do_insert;
    logic [7:0]             ins_byte;
    logic [7:0]             len_byte;
    logic [63:0]            count_sum;
    logic [31:0]            sched_word;

    assign o_in_ready = (r_state == sha0_pkg::ST_IDLE);
    assign in_beat    = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == sha0_pkg::ST_OUT) || (r_state == sha0_pkg::ST_ERR);
    assign out_beat   = o_out_valid && i_out_ready;

    always_comb begin
        o_digest_word  = 32'd0;
        o_word_index   = 3'd0;
        o_last_word    = 1'b1;
        o_length_error = 1'b1;
        if (r_state == sha0_pkg::ST_OUT) begin
            o_digest_word  = r_chain[r_idx];
            o_word_index   = r_idx;
            o_last_word    = (r_idx == sha0_pkg::LastWord);
            o_length_error = 1'b0;
        end
    end

    // length bytes go out most significant first at positions 56 to 63
    assign len_byte   = 8'(r_bit_count >> {~r_pos[2:0], 3'b000});
    assign count_sum  = r_bit_count + 64'd8;
    assign sched_word = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];

    sha0_round u_round (
        .i_cur   (r_rs),
        .i_w     (r_w[0]),
        .i_round (r_round),
        .o_next  (round_out)
    );

    always_comb begin
        do_insert = 1'b0;
        ins_byte  = i_data_byte;
        if (r_state == sha0_pkg::ST_IDLE) begin
            do_insert = in_beat && (i_kind == sha0_pkg::KindByte) && !r_overflow;
        end else if (r_state == sha0_pkg::ST_PAD) begin
            do_insert = 1'b1;
            if (!r_mark_sent) begin
                ins_byte = sha0_pkg::PadMark;
            end else if (r_pos >= 6'd56 && !r_fill) begin
                ins_byte = len_byte;
            end else begin
                ins_byte = 8'd0;
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_chain      = r_chain;
        n_w          = r_w;
        n_rs         = r_rs;
        n_round      = r_round;
        n_bit_count  = r_bit_count;
        n_pos        = r_pos;
        n_overflow   = r_overflow;
        n_mark_sent  = r_mark_sent;
        n_fill       = r_fill;
        n_last_block = r_last_block;
        n_padding    = r_padding;
        n_idx        = r_idx;

        if (do_insert) begin
            for (int k = 0; k < 15; k++) begin
                n_w[k] = {r_w[k][23:0], r_w[k + 1][31:24]};
            end
            n_w[15] = {r_w[15][23:0], ins_byte};
            n_pos   = r_pos + 6'd1;
            if (r_pos == 6'd63) begin
                n_state = sha0_pkg::ST_ROUND;
                n_round = 7'd0;
                n_rs    = '{a: r_chain[0], b: r_chain[1], c: r_chain[2],
                            d: r_chain[3], e: r_chain[4]};
                n_fill  = 1'b0;
            end
        end

        unique case (r_state)
            sha0_pkg::ST_IDLE: begin
                if (in_beat && i_kind == sha0_pkg::KindByte && !r_overflow) begin
                    n_bit_count = count_sum;
                    if (count_sum == 64'd0) begin
                        n_overflow = 1'b1;
                    end
                end else if (in_beat && i_kind == sha0_pkg::KindFinish) begin
                    n_state   = r_overflow ? sha0_pkg::ST_ERR : sha0_pkg::ST_PAD;
                    n_padding = !r_overflow;
                end
            end
            sha0_pkg::ST_PAD: begin
                if (!r_mark_sent) begin
                    n_mark_sent = 1'b1;
                    // mark too late for the length: this block is zero fill only
                    if (r_pos >= 6'd56 && r_pos != 6'd63) begin
                        n_fill = 1'b1;
                    end
                end
                if (r_pos == 6'd63 && r_mark_sent && !r_fill) begin
                    n_last_block = 1'b1;
                end else if (r_pos == 6'd63 && !r_mark_sent) begin
                    // mark in the last slot: the next block carries the length
                    n_last_block = 1'b0;
                end
            end
            sha0_pkg::ST_ROUND: begin
                n_rs = round_out;
                for (int k = 0; k < 15; k++) begin
                    n_w[k] = r_w[k + 1];
                end
                n_w[15] = sched_word;
                n_round = r_round + 7'd1;
                if (r_round == sha0_pkg::LastRound) begin
                    n_state = sha0_pkg::ST_FOLD;
                end
            end
            sha0_pkg::ST_FOLD: begin
                n_chain[0] = r_chain[0] + r_rs.a;
                n_chain[1] = r_chain[1] + r_rs.b;
                n_chain[2] = r_chain[2] + r_rs.c;
                n_chain[3] = r_chain[3] + r_rs.d;
                n_chain[4] = r_chain[4] + r_rs.e;
                if (r_last_block) begin
                    n_state = sha0_pkg::ST_OUT;
                    n_idx   = 3'd0;
                end else if (r_padding) begin
                    n_state = sha0_pkg::ST_PAD;
                end else begin
                    n_state = sha0_pkg::ST_IDLE;
                end
            end
            sha0_pkg::ST_OUT: begin
                if (out_beat) begin
                    n_idx = r_idx + 3'd1;
                end
            end
            sha0_pkg::ST_ERR: begin
            end
            default: begin
                n_state = sha0_pkg::ST_IDLE;
            end
        endcase

        // final beat of a run returns everything to the start of a message
        if (out_beat && o_last_word) begin
            n_state      = sha0_pkg::ST_IDLE;
            n_chain      = '{sha0_pkg::H0, sha0_pkg::H1, sha0_pkg::H2,
                             sha0_pkg::H3, sha0_pkg::H4};
            n_bit_count  = 64'd0;
            n_pos        = 6'd0;
            n_overflow   = 1'b0;
            n_mark_sent  = 1'b0;
            n_fill       = 1'b0;
            n_last_block = 1'b0;
            n_padding    = 1'b0;
            n_idx        = 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sha0_pkg::ST_IDLE;
            r_chain      <= '{sha0_pkg::H0, sha0_pkg::H1, sha0_pkg::H2,
                              sha0_pkg::H3, sha0_pkg::H4};
            r_round      <= 7'd0;
            r_bit_count  <= 64'd0;
            r_pos        <= 6'd0;
            r_overflow   <= 1'b0;
            r_mark_sent  <= 1'b0;
            r_fill       <= 1'b0;
            r_last_block <= 1'b0;
            r_padding    <= 1'b0;
            r_idx        <= 3'd0;
        end else begin
            r_state      <= n_state;
            r_chain      <= n_chain;
            r_round      <= n_round;
            r_bit_count  <= n_bit_count;
            r_pos        <= n_pos;
            r_overflow   <= n_overflow;
            r_mark_sent  <= n_mark_sent;
            r_fill       <= n_fill;
            r_last_block <= n_last_block;
            r_padding    <= n_padding;
            r_idx        <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w  <= n_w;
        r_rs <= n_rs;
    end

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha0_pkg::ST_ROUND) |-> (r_round <= sha0_pkg::LastRound))
        else $error("round counter past last round");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_length_error) |-> (o_last_word && o_digest_word == 32'd0))
        else $error("error beat not marked last or carries data");

    a_ready_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && o_last_word) |=> (o_in_ready && r_pos == 6'd0 && !r_overflow))
        else $error("block not back at message start after last beat");

    a_pad_ends_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha0_pkg::ST_PAD && r_pos == 6'd63) |=> (r_state == sha0_pkg::ST_ROUND))
        else $error("padding did not start a compression at block end");

    a_fold_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha0_pkg::ST_ROUND && r_round == sha0_pkg::LastRound)
        |=> (r_state == sha0_pkg::ST_FOLD))
        else $error("fold did not follow the last round");

endmodule

`default_nettype wire

// ===== design/sha0_round.sv =====
// sha0_round: one sha-0 compression round, reused for all 80 rounds
// depends on sha0_pkg (round state type, round constants)
`default_nettype none

module sha0_round (
    input  wire sha0_pkg::t_round_state i_cur,
    input  wire logic [31:0]            i_w,
    input  wire logic [6:0]             i_round,
    output sha0_pkg::t_round_state      o_next
);

    logic [31:0] f;
    logic [31:0] k;

    // round group picks both the boolean function and the constant
    always_comb begin
        if (i_round < 7'd20) begin
            f = (i_cur.b & i_cur.c) | (~i_cur.b & i_cur.d);
            k = sha0_pkg::K0;
        end else if (i_round < 7'd40) begin
            f = i_cur.b ^ i_cur.c ^ i_cur.d;
            k = sha0_pkg::K1;
        end else if (i_round < 7'd60) begin
            f = (i_cur.b & i_cur.c) | (i_cur.b & i_cur.d) | (i_cur.c & i_cur.d);
            k = sha0_pkg::K2;
        end else begin
            f = i_cur.b ^ i_cur.c ^ i_cur.d;
            k = sha0_pkg::K3;
        end
    end

    always_comb begin
        o_next.a = sha0_pkg::rotl(i_cur.a, 5) + f + i_cur.e + i_w + k;
        o_next.b = i_cur.a;
        o_next.c = sha0_pkg::rotl(i_cur.b, 30);
        o_next.d = i_cur.c;
        o_next.e = i_cur.d;
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for sha0_message_hash, predicts every digest beat in-bench
// depends on sha0_pkg for constants; drives random bytes and finishes with random stalls

module tb;

    localparam int unsigned ClkPeriod   = 12;
    localparam int unsigned LimitCycles = 300_000;
    // a finish can pad up to 72 bytes and run two compressions before the first beat
    localparam int unsigned DrainCycles = 400;
    localparam int unsigned IdlePercent = 31;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
        logic        len_err;
    } t_digest_beat;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_kind      = sha0_pkg::KindByte;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;
    logic        o_length_error;

    // hash state as the block should hold it
    logic [7:0]   msg_block [64];
    logic [31:0]  chain [sha0_pkg::WordCount];
    logic [63:0]  msg_bits;
    logic [5:0]   fill_pos;
    logic         bits_wrapped;
    t_digest_beat digest_q [$];

    int mismatch_count = 0;
    bit steady         = 1'b0;
    int hold_left      = 0;

    sha0_message_hash DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_last_word    (o_last_word),
        .o_length_error (o_length_error)
    );

    initial begin
        forever #(ClkPeriod / 2) i_clk = ~i_clk;
    end

    initial begin
        #(LimitCycles * ClkPeriod);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void clear_hash();
        chain[0]     = sha0_pkg::H0;
        chain[1]     = sha0_pkg::H1;
        chain[2]     = sha0_pkg::H2;
        chain[3]     = sha0_pkg::H3;
        chain[4]     = sha0_pkg::H4;
        msg_bits     = '0;
        fill_pos     = '0;
        bits_wrapped = 1'b0;
    endfunction

    // 80 rounds over msg_block; schedule without the one-bit rotate
    function automatic void compress_chain();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, sum;
        for (int t = 0; t < 16; t++) begin
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int t = 0; t < sha0_pkg::RoundCount; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                wt = w[(t-3) & 15] ^ w[(t-8) & 15] ^ w[(t-14) & 15] ^ w[t & 15];
                w[t & 15] = wt;
            end
            if (t < 20) begin
                f = (b & c) | (~b & d);
                k = sha0_pkg::K0;
            end else if (t < 40) begin
                f = b ^ c ^ d;
                k = sha0_pkg::K1;
            end else if (t < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = sha0_pkg::K2;
            end else begin
                f = b ^ c ^ d;
                k = sha0_pkg::K3;
            end
            sum = {a[26:0], a[31:27]} + f + e + wt + k;
            e   = d;
            d   = c;
            c   = {b[1:0], b[31:2]};
            b   = a;
            a   = sum;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    // a wrap of the bit count takes 2^61 bytes, so that branch is kept but never reached
    function automatic void absorb_beat(input logic kind, input logic [7:0] data);
        int           p;
        t_digest_beat beat;
        if (kind == sha0_pkg::KindByte) begin
            if (!bits_wrapped) begin
                msg_block[fill_pos] = data;
                fill_pos = fill_pos + 6'd1;
                msg_bits = msg_bits + 64'd8;
                if (msg_bits == '0) bits_wrapped = 1'b1;
                if (fill_pos == '0) compress_chain();
            end
        end else if (bits_wrapped) begin
            beat.word    = '0;
            beat.index   = '0;
            beat.last    = 1'b1;
            beat.len_err = 1'b1;
            digest_q.push_back(beat);
            clear_hash();
        end else begin
            p = fill_pos;
            msg_block[p] = sha0_pkg::PadMark;
            p++;
            // no room for the length: pad out this block and start another
            if (p > 56) begin
                while (p < 64) begin
                    msg_block[p] = 8'h00;
                    p++;
                end
                compress_chain();
                p = 0;
            end
            while (p < 56) begin
                msg_block[p] = 8'h00;
                p++;
            end
            for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
            compress_chain();
            for (int i = 0; i < sha0_pkg::WordCount; i++) begin
                beat.word    = chain[i];
                beat.index   = 3'(i);
                beat.last    = (i == sha0_pkg::WordCount - 1);
                beat.len_err = 1'b0;
                digest_q.push_back(beat);
            end
            clear_hash();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // returns in the time step of the edge that accepted the beat
    task automatic send_beat(input logic kind, input logic [7:0] data);
        int gap;
        gap = (!steady && $urandom_range(99) < IdlePercent) ? $urandom_range(4, 1) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        absorb_beat(kind, data);
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) send_beat(sha0_pkg::KindByte, 8'($urandom));
        send_beat(sha0_pkg::KindFinish, 8'($urandom));
    endtask

    initial begin : digest_sink
        t_digest_beat want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_out_ready && o_out_valid !== 1'b0) begin
                if (digest_q.size() == 0) begin
                    report_mismatch("beat with no digest pending", o_digest_word, '0);
                end else begin
                    want = digest_q.pop_front();
                    if (o_digest_word !== want.word)
                        report_mismatch("digest_word", o_digest_word, want.word);
                    if (o_word_index !== want.index)
                        report_mismatch("word_index", 32'(o_word_index), 32'(want.index));
                    if (o_last_word !== want.last)
                        report_mismatch("last_word", 32'(o_last_word), 32'(want.last));
                    if (o_length_error !== want.len_err)
                        report_mismatch("length_error", 32'(o_length_error), 32'(want.len_err));
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IdlePercent);
            end
        end
    end

    task automatic test_directed();
        send_beat(sha0_pkg::KindFinish, 8'hFF);   // empty message, byte ignored on finish
        send_beat(sha0_pkg::KindByte, 8'h61);
        send_beat(sha0_pkg::KindByte, 8'h62);
        send_beat(sha0_pkg::KindByte, 8'h63);
        send_beat(sha0_pkg::KindFinish, 8'h00);
        send_beat(sha0_pkg::KindByte, 8'h00);
        send_beat(sha0_pkg::KindByte, 8'hFF);
        send_beat(sha0_pkg::KindByte, 8'h80);
        send_beat(sha0_pkg::KindFinish, 8'h5A);
        send_beat(sha0_pkg::KindFinish, 8'h00);   // finish right after a finish
    endtask

    // length fits one padded block, spills into a second, and fills a block exactly
    task automatic test_pad_boundaries();
        send_message(55);
        send_message(56);
        send_message(64);
    endtask

    // receiver shut while the sender keeps offering: input must stall behind the digest
    task automatic test_output_stall();
        hold_left = 400;
        send_message(12);
        send_message(30);
        send_message(0);
    endtask

    task automatic test_drain_pause();
        send_message(20);
        i_in_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        send_message(5);
    endtask

    task automatic test_random();
        int n_items;
        int n_msgs;
        int len;
        int roll;
        n_items = 0;
        n_msgs  = 0;
        while (n_items < 140 || n_msgs < 5) begin
            steady = (n_msgs >= 1 && n_msgs < 4);
            roll = $urandom_range(99);
            if (roll < 10)      len = 0;
            else if (roll < 65) len = $urandom_range(20, 1);
            else if (roll < 90) len = $urandom_range(70, 21);
            else                len = $urandom_range(140, 71);
            send_message(len);
            n_items += len + 1;
            n_msgs++;
        end
        steady = 1'b0;
    endtask

    initial begin
        clear_hash();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pad_boundaries();
        test_output_stall();
        test_drain_pause();
        test_random();
        i_in_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
